// File: hdl/reorder_id_wrap_arithmetic_defines.svh
// ----------------------------------------------------------------------------
// Reorder ID wrap arithmetic: assertion macros
// Shared assertion forms for the checker of the reorder ID unit.
// ----------------------------------------------------------------------------
`ifndef REORDER_ID_WRAP_ARITHMETIC_DEFINES_SVH
`define REORDER_ID_WRAP_ARITHMETIC_DEFINES_SVH

// Check on every clock edge outside reset.
`define RIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define RIDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/rida_pkg.sv
// ----------------------------------------------------------------------------
// Reorder ID wrap arithmetic package
// Request codes, shared constants and the per-item control word.
// ----------------------------------------------------------------------------
package rida_pkg;

  localparam int INDEX_BITS_DEF = 8;
  localparam int OFFSET_W       = 8;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;

  // Register indexes
  localparam int REG_RING_SIZE  = 0;

  typedef enum logic [2:0] {
    REQ_ADVANCE  = 3'd0,
    REQ_RETREAT  = 3'd1,
    REQ_DISTANCE = 3'd2,
    REQ_LESS     = 3'd3,
    REQ_LESS_EQ  = 3'd4
  } req_e;

  typedef struct packed {
    logic is_adv;
    logic is_ret;
    logic is_dist;
    logic err;
    logic cmp;
    logic borrow;
  } op_t;

endpackage

// File: hdl/rida_cfg.sv
// ----------------------------------------------------------------------------
// Reorder ID configuration register
// APB slave holding ring_size and its clamped working copy.
// ----------------------------------------------------------------------------
module rida_cfg #(
  parameter int INDEX_BITS = rida_pkg::INDEX_BITS_DEF,
  localparam int IDW = INDEX_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [rida_pkg::APB_AW-1:0]   paddr_i,
  input  logic [rida_pkg::APB_DW-1:0]   pwdata_i,
  output logic [rida_pkg::APB_DW-1:0]   prdata_o,
  output logic                          pready_o,
  output logic [IDW-1:0]                size_o
);

  localparam logic [IDW-1:0] SIZE_MAX = IDW'(1) << INDEX_BITS;
  localparam logic [IDW-1:0] SIZE_MIN = IDW'(2);

  logic [IDW-1:0] ring_size_q, ring_size_d;
  logic [IDW-1:0] eff_size_q, eff_size_d;
  logic           reg_hit;
  logic           wr_en;

  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[rida_pkg::APB_AW-1:2] == 1'(rida_pkg::REG_RING_SIZE));
  assign wr_en    = psel_i && penable_i && pwrite_i && reg_hit;

  always_comb begin
    ring_size_d = pwdata_i[IDW-1:0];
    if (ring_size_d < SIZE_MIN) begin
      eff_size_d = SIZE_MIN;
    end else if (ring_size_d > SIZE_MAX) begin
      eff_size_d = SIZE_MAX;
    end else begin
      eff_size_d = ring_size_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= SIZE_MAX;
      eff_size_q  <= SIZE_MAX;
    end else if (wr_en) begin
      ring_size_q <= ring_size_d;
      eff_size_q  <= eff_size_d;
    end
  end

  assign prdata_o = reg_hit ? rida_pkg::APB_DW'(ring_size_q) : '0;
  assign size_o   = eff_size_q;

endmodule

// File: hdl/rida_front.sv
// ----------------------------------------------------------------------------
// Reorder ID front stage
// Decode the request, resolve the ordering compare and start the sums.
// ----------------------------------------------------------------------------
module rida_front #(
  parameter int INDEX_BITS = rida_pkg::INDEX_BITS_DEF,
  localparam int IDW = INDEX_BITS + 1,
  localparam int AW  = ((INDEX_BITS > rida_pkg::OFFSET_W) ? INDEX_BITS
                                                          : rida_pkg::OFFSET_W) + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0]                    req_i,
  input  logic [1:0]                    levels_i,
  input  logic [rida_pkg::OFFSET_W-1:0] offset_i,
  input  logic [IDW-1:0]                a_blk_i,
  input  logic [IDW-1:0]                a_grp_i,
  input  logic [IDW-1:0]                a_ent_i,
  input  logic [IDW-1:0]                b_blk_i,
  input  logic [IDW-1:0]                b_grp_i,
  input  logic [IDW-1:0]                b_ent_i,
  input  logic [IDW-1:0]                size_i,
  output logic                          valid_o,
  output rida_pkg::op_t                 op_o,
  output logic [IDW-1:0]                a_blk_o,
  output logic [AW-1:0]                 sum_o,
  output logic [INDEX_BITS-1:0]         dfwd_o,
  output logic [AW-1:0]                 dbwd_o,
  output logic [AW-1:0]                 bvx_o,
  output logic [INDEX_BITS-1:0]         sv_o,
  output logic                          neg_o
);

  function automatic logic id_less(input logic [IDW-1:0] x, input logic [IDW-1:0] y);
    if (x[INDEX_BITS] == y[INDEX_BITS]) begin
      return x[INDEX_BITS-1:0] < y[INDEX_BITS-1:0];
    end
    return x[INDEX_BITS-1:0] > y[INDEX_BITS-1:0];
  endfunction

  logic                  valid_q;
  rida_pkg::op_t         op_q, op_d;
  logic [IDW-1:0]        a_blk_q;
  logic [AW-1:0]         sum_q, sum_d;
  logic [INDEX_BITS-1:0] dfwd_q, dfwd_d;
  logic [AW-1:0]         dbwd_q, dbwd_d;
  logic [AW-1:0]         bvx_q, bvx_d;
  logic [INDEX_BITS-1:0] sv_q, sv_d;
  logic                  neg_q, neg_d;

  logic [AW-1:0]         idx_x, off_x, size_x;
  logic                  lt0, gt0, lt1, gt1, lt2, gt2;
  logic                  is_le, r0, r1, r2;
  logic                  range_err;
  logic [IDW-1:0]        big, sml;

  always_comb begin
    idx_x  = AW'(a_blk_i[INDEX_BITS-1:0]);
    off_x  = AW'(offset_i);
    size_x = AW'(size_i);

    lt0 = id_less(a_blk_i, b_blk_i);
    gt0 = id_less(b_blk_i, a_blk_i);
    lt1 = id_less(a_grp_i, b_grp_i);
    gt1 = id_less(b_grp_i, a_grp_i);
    lt2 = id_less(a_ent_i, b_ent_i);
    gt2 = id_less(b_ent_i, a_ent_i);

    // A tie on every examined level falls back to the or-equal flavor
    is_le = (req_i == rida_pkg::REQ_LESS_EQ);
    r2 = (levels_i >= 2'd2) ? (lt2 ? 1'b1 : (gt2 ? 1'b0 : is_le)) : is_le;
    r1 = (levels_i == 2'd3) ? (lt1 ? 1'b1 : (gt1 ? 1'b0 : r2)) : r2;
    r0 = lt0 ? 1'b1 : (gt0 ? 1'b0 : r1);

    range_err = (off_x >= size_x);

    sum_d  = idx_x + off_x;
    dfwd_d = INDEX_BITS'(idx_x - off_x);
    dbwd_d = off_x - idx_x;

    // Order the pair so the larger one carries the ring crossing
    neg_d = lt0;
    big   = lt0 ? b_blk_i : a_blk_i;
    sml   = lt0 ? a_blk_i : b_blk_i;
    bvx_d = AW'(big[INDEX_BITS-1:0]) + ((big[INDEX_BITS] != sml[INDEX_BITS]) ? size_x : '0);
    sv_d  = sml[INDEX_BITS-1:0];

    op_d        = '0;
    op_d.borrow = (idx_x < off_x);
    case (rida_pkg::req_e'(req_i))
      rida_pkg::REQ_ADVANCE: begin
        op_d.is_adv = 1'b1;
        op_d.err    = range_err;
      end
      rida_pkg::REQ_RETREAT: begin
        op_d.is_ret = 1'b1;
        op_d.err    = range_err;
      end
      rida_pkg::REQ_DISTANCE: begin
        op_d.is_dist = 1'b1;
      end
      rida_pkg::REQ_LESS, rida_pkg::REQ_LESS_EQ: begin
        op_d.cmp = r0;
      end
      default: begin
        op_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      op_q    <= op_d;
      a_blk_q <= a_blk_i;
      sum_q   <= sum_d;
      dfwd_q  <= dfwd_d;
      dbwd_q  <= dbwd_d;
      bvx_q   <= bvx_d;
      sv_q    <= sv_d;
      neg_q   <= neg_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign a_blk_o = a_blk_q;
  assign sum_o   = sum_q;
  assign dfwd_o  = dfwd_q;
  assign dbwd_o  = dbwd_q;
  assign bvx_o   = bvx_q;
  assign sv_o    = sv_q;
  assign neg_o   = neg_q;

endmodule

// File: hdl/rida_mid.sv
// ----------------------------------------------------------------------------
// Reorder ID middle stage
// Fold the ring size into the moved ID and form the raw distance.
// ----------------------------------------------------------------------------
module rida_mid #(
  parameter int INDEX_BITS = rida_pkg::INDEX_BITS_DEF,
  localparam int IDW = INDEX_BITS + 1,
  localparam int AW  = ((INDEX_BITS > rida_pkg::OFFSET_W) ? INDEX_BITS
                                                          : rida_pkg::OFFSET_W) + 2,
  localparam int DW  = AW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  rida_pkg::op_t         op_i,
  input  logic [IDW-1:0]        a_blk_i,
  input  logic [AW-1:0]         sum_i,
  input  logic [INDEX_BITS-1:0] dfwd_i,
  input  logic [AW-1:0]         dbwd_i,
  input  logic [AW-1:0]         bvx_i,
  input  logic [INDEX_BITS-1:0] sv_i,
  input  logic                  neg_i,
  input  logic [IDW-1:0]        size_i,
  output logic                  valid_o,
  output rida_pkg::op_t         op_o,
  output logic [IDW-1:0]        res_o,
  output logic [DW-1:0]         raw_o,
  output logic                  neg_o
);

  logic          valid_q;
  rida_pkg::op_t op_q;
  logic [IDW-1:0] res_q, res_d;
  logic [DW-1:0]  raw_q, raw_d;
  logic           neg_q;

  logic [AW-1:0]  size_x, adv_v, ret_v;
  logic           wa;

  always_comb begin
    size_x = AW'(size_i);
    wa     = a_blk_i[INDEX_BITS];
    adv_v  = sum_i - size_x;
    ret_v  = size_x - dbwd_i;

    res_d = '0;
    if (op_i.err) begin
      res_d = a_blk_i;
    end else if (op_i.is_adv) begin
      res_d = (sum_i >= size_x) ? {~wa, adv_v[INDEX_BITS-1:0]} : {wa, sum_i[INDEX_BITS-1:0]};
    end else if (op_i.is_ret) begin
      res_d = op_i.borrow ? {~wa, ret_v[INDEX_BITS-1:0]} : {wa, dfwd_i};
    end

    raw_d = DW'(bvx_i) - DW'(sv_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      op_q  <= op_i;
      res_q <= res_d;
      raw_q <= raw_d;
      neg_q <= neg_i;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign res_o   = res_q;
  assign raw_o   = raw_q;
  assign neg_o   = neg_q;

endmodule

// File: hdl/rida_out.sv
// ----------------------------------------------------------------------------
// Reorder ID output stage
// Saturate and sign the distance, then hold the finished result.
// ----------------------------------------------------------------------------
module rida_out #(
  parameter int INDEX_BITS = rida_pkg::INDEX_BITS_DEF,
  localparam int IDW = INDEX_BITS + 1,
  localparam int AW  = ((INDEX_BITS > rida_pkg::OFFSET_W) ? INDEX_BITS
                                                          : rida_pkg::OFFSET_W) + 2,
  localparam int DW  = AW + 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rida_pkg::op_t  op_i,
  input  logic [IDW-1:0] res_i,
  input  logic [DW-1:0]  raw_i,
  input  logic           neg_i,
  output logic           valid_o,
  output logic [IDW-1:0] result_id_o,
  output logic [IDW-1:0] distance_o,
  output logic           compare_true_o,
  output logic           offset_error_o
);

  localparam logic signed [DW-1:0] LIM = DW'((1 << INDEX_BITS) - 1);

  logic                  valid_q;
  logic [IDW-1:0]        res_q;
  logic [IDW-1:0]        dist_q, dist_d;
  logic                  cmp_q;
  logic                  err_q;
  logic signed [DW-1:0]  raw_s, clp;

  always_comb begin
    raw_s = $signed(raw_i);
    if (raw_s > LIM) begin
      clp = LIM;
    end else if (raw_s < -LIM) begin
      clp = -LIM;
    end else begin
      clp = raw_s;
    end
    if (neg_i) begin
      clp = -clp;
    end
    dist_d = op_i.is_dist ? clp[IDW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      res_q  <= res_i;
      dist_q <= dist_d;
      cmp_q  <= op_i.cmp;
      err_q  <= op_i.err;
    end
  end

  assign valid_o        = valid_q;
  assign result_id_o    = res_q;
  assign distance_o     = dist_q;
  assign compare_true_o = cmp_q;
  assign offset_error_o = err_q;

endmodule

// File: hdl/reorder_id_wrap_arithmetic.sv
// An accepted input transaction passes the front, middle and output stage registers in turn.
// Throughput: one transaction per cycle; the three pipeline registers advance
// together and freeze while the output transaction waits on m_axis_tready.
// Reset: asynchronous, active low; clears all stage valid bits and sets
// ring_size to 2**INDEX_BITS.
// ----------------------------------------------------------------------------
// Reorder ID wrap arithmetic
// Advance, retreat, distance and ordering compare of wrap-bit ring IDs.
// ----------------------------------------------------------------------------
module reorder_id_wrap_arithmetic #(
  parameter int INDEX_BITS = rida_pkg::INDEX_BITS_DEF,
  localparam int IDW    = INDEX_BITS + 1,
  localparam int IN_DW  = ((rida_pkg::OFFSET_W + 6 * IDW + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * IDW + 2 + 7) / 8) * 8,
  localparam int AW     = ((INDEX_BITS > rida_pkg::OFFSET_W) ? INDEX_BITS
                                                             : rida_pkg::OFFSET_W) + 2,
  localparam int DW     = AW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // offset, a_block_id, a_group_id, a_entry_id, b_block_id, b_group_id, b_entry_id
  input  logic [IN_DW-1:0]            s_axis_tdata,
  // req_type, key_levels
  input  logic [4:0]                  s_axis_tuser,
  // Output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // result_id, distance, compare_true, offset_error
  output logic [OUT_DW-1:0]           m_axis_tdata,
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rida_pkg::APB_AW-1:0] paddr,
  input  logic [rida_pkg::APB_DW-1:0] pwdata,
  output logic [rida_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int OFS_A_BLK = rida_pkg::OFFSET_W;
  localparam int OFS_A_GRP = OFS_A_BLK + IDW;
  localparam int OFS_A_ENT = OFS_A_GRP + IDW;
  localparam int OFS_B_BLK = OFS_A_ENT + IDW;
  localparam int OFS_B_GRP = OFS_B_BLK + IDW;
  localparam int OFS_B_ENT = OFS_B_GRP + IDW;

  logic                  en;
  logic [IDW-1:0]        size;

  logic                  v1;
  rida_pkg::op_t         op1;
  logic [IDW-1:0]        a_blk1;
  logic [AW-1:0]         sum1, dbwd1, bvx1;
  logic [INDEX_BITS-1:0] dfwd1, sv1;
  logic                  neg1;

  logic                  v2;
  rida_pkg::op_t         op2;
  logic [IDW-1:0]        res2;
  logic [DW-1:0]         raw2;
  logic                  neg2;

  logic [IDW-1:0]        result_id, distance;
  logic                  compare_true, offset_error;

  // Advance the whole pipe unless the held result is refused
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rida_cfg #(.INDEX_BITS(INDEX_BITS)) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .size_o    (size)
  );

  rida_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .req_i    (s_axis_tuser[2:0]),
    .levels_i (s_axis_tuser[4:3]),
    .offset_i (s_axis_tdata[rida_pkg::OFFSET_W-1:0]),
    .a_blk_i  (s_axis_tdata[OFS_A_BLK +: IDW]),
    .a_grp_i  (s_axis_tdata[OFS_A_GRP +: IDW]),
    .a_ent_i  (s_axis_tdata[OFS_A_ENT +: IDW]),
    .b_blk_i  (s_axis_tdata[OFS_B_BLK +: IDW]),
    .b_grp_i  (s_axis_tdata[OFS_B_GRP +: IDW]),
    .b_ent_i  (s_axis_tdata[OFS_B_ENT +: IDW]),
    .size_i   (size),
    .valid_o  (v1),
    .op_o     (op1),
    .a_blk_o  (a_blk1),
    .sum_o    (sum1),
    .dfwd_o   (dfwd1),
    .dbwd_o   (dbwd1),
    .bvx_o    (bvx1),
    .sv_o     (sv1),
    .neg_o    (neg1)
  );

  rida_mid #(.INDEX_BITS(INDEX_BITS)) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .op_i    (op1),
    .a_blk_i (a_blk1),
    .sum_i   (sum1),
    .dfwd_i  (dfwd1),
    .dbwd_i  (dbwd1),
    .bvx_i   (bvx1),
    .sv_i    (sv1),
    .neg_i   (neg1),
    .size_i  (size),
    .valid_o (v2),
    .op_o    (op2),
    .res_o   (res2),
    .raw_o   (raw2),
    .neg_o   (neg2)
  );

  rida_out #(.INDEX_BITS(INDEX_BITS)) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (v2),
    .op_i           (op2),
    .res_i          (res2),
    .raw_i          (raw2),
    .neg_i          (neg2),
    .valid_o        (m_axis_tvalid),
    .result_id_o    (result_id),
    .distance_o     (distance),
    .compare_true_o (compare_true),
    .offset_error_o (offset_error)
  );

  assign m_axis_tdata = OUT_DW'({offset_error, compare_true, distance, result_id});

endmodule

// File: hdl/rida_checker.sv
// ----------------------------------------------------------------------------
// Reorder ID port checker
// Watches the stream ports of the reorder ID unit for result consistency and an empty pipe in reset.
// ----------------------------------------------------------------------------
module rida_checker #(
  parameter int INDEX_BITS = rida_pkg::INDEX_BITS_DEF,
  localparam int IDW    = INDEX_BITS + 1,
  localparam int OUT_DW = ((2 * IDW + 2 + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata
);

`include "reorder_id_wrap_arithmetic_defines.svh"

  logic [IDW-1:0] result_id, distance;
  logic           compare_true, offset_error;

  assign result_id    = m_axis_tdata[IDW-1:0];
  assign distance     = m_axis_tdata[2*IDW-1:IDW];
  assign compare_true = m_axis_tdata[2*IDW];
  assign offset_error = m_axis_tdata[2*IDW+1];

  `RIDA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `RIDA_ASSERT(a_err_alone, m_axis_tvalid && offset_error |-> distance == '0 && !compare_true, "offset error mixed with other results")
  `RIDA_ASSERT(a_dist_alone, m_axis_tvalid && distance != '0 |-> result_id == '0 && !compare_true, "distance mixed with other results")
  `RIDA_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !m_axis_tvalid && s_axis_tready, "pipe not empty in reset")

endmodule

bind reorder_id_wrap_arithmetic rida_checker #(.INDEX_BITS(INDEX_BITS)) u_rida_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
